@@ rtl/core/bfjd_pkg.sv @@
`timescale 1ns / 1ps

package bfjd_pkg;

  localparam int TIME_W  = 32;
  localparam int ID_W    = 16;
  localparam int LEN_W   = 16;
  localparam int LIMIT_W = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd3;

  // One request retires at most this many records, which caps the usable limit.
  localparam int MAX_RECORDS         = 4;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    OUT_DONE         = 2'd0,
    OUT_DROPPED      = 2'd1,
    OUT_EXPIRED_WAIT = 2'd2,
    OUT_EXPIRED_RUN  = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] arrival_time;
    logic [LEN_W-1:0]  run_length;
    logic [TIME_W-1:0] deadline;
    logic              final_job;
  } job_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_job_id;
    outcome_t          outcome;
    logic [TIME_W-1:0] event_time;
    logic [TIME_W-1:0] wait_delay;
    logic              run_end;
  } result_t;

  // A request as the front hands it on, with its finish time on an idle server.
  typedef struct packed {
    job_t              job;
    logic [TIME_W-1:0] idle_finish;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RUN,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    back_state_t state;
    logic        draining;
    logic        queue_empty;
  } back_status_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

@@ rtl/core/bfjd_front.sv @@
`timescale 1ns / 1ps

module bfjd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_stall,
  input  bfjd_pkg::job_t job,
  output logic          cmd_push,
  input  logic          cmd_full,
  output bfjd_pkg::cmd_t cmd
);
  import bfjd_pkg::*;

  logic held_valid;
  logic accept;

  // The holding register frees up in the same cycle it hands its request on.
  assign job_stall = held_valid && cmd_full;
  assign accept    = job_valid && !job_stall;
  assign cmd_push  = held_valid && !cmd_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (cmd_push) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.job         <= job;
      cmd.idle_finish <= sat_add(job.arrival_time, {{(TIME_W-LEN_W){1'b0}}, job.run_length});
    end
  end

endmodule

@@ rtl/core/bfjd_cmd_queue.sv @@
`timescale 1ns / 1ps

module bfjd_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bfjd_pkg::cmd_t push_data,
  output logic           full,
  output logic           not_empty,
  input  logic           pop,
  output bfjd_pkg::cmd_t head
);
  import bfjd_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/core/bfjd_back.sv @@
`timescale 1ns / 1ps

module bfjd_back #(
  parameter int QUEUE_DEPTH = bfjd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [bfjd_pkg::LIMIT_W-1:0]    queue_limit,
  input  logic                            cmd_valid,
  input  bfjd_pkg::cmd_t                  cmd,
  output logic                            cmd_pop,
  output logic                            result_valid,
  input  logic                            result_stall,
  output bfjd_pkg::result_t               result,
  output bfjd_pkg::back_status_t          status
);
  import bfjd_pkg::*;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W   = PTR_W + 1;
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int LIM_CAP = (MAX_RECORDS - 1 < QUEUE_DEPTH) ? MAX_RECORDS - 1 : QUEUE_DEPTH;

  typedef struct packed {
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] arrival_time;
    logic [LEN_W-1:0]  run_length;
    logic [TIME_W-1:0] deadline;
  } entry_t;

  entry_t store [QUEUE_DEPTH];

  back_state_t       state;
  back_state_t       state_next;
  logic [PTR_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [TIME_W-1:0] server_time;
  logic              draining;
  logic              run_eq;
  cmd_t              cur;

  outcome_t          run_outcome;
  logic [TIME_W-1:0] run_time;
  logic [TIME_W-1:0] run_delay;
  logic [TIME_W-1:0] run_server;

  logic [CMP_W-1:0]  lim;
  logic [CMP_W-1:0]  count_x;
  logic [CMP_W-1:0]  count_after;
  logic [IDX_W-1:0]  tail_sum;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  head_inc;
  logic              arr_lt;
  logic              arr_eq;
  logic              has_room;
  logic              out_free;
  logic              more;
  entry_t            head_entry;
  logic [TIME_W-1:0] fin;

  logic              emit;
  result_t           emit_rec;
  logic              push_cur;
  logic              pop_head;
  logic              load_server;
  logic [TIME_W-1:0] server_value;
  logic              drain_start;
  logic              capture_run;
  logic              load_eq;

  assign lim = (CMP_W'(queue_limit) > CMP_W'(LIM_CAP)) ? CMP_W'(LIM_CAP)
                                                       : CMP_W'(queue_limit);
  assign count_x     = CMP_W'(count);
  assign count_after = count_x - CMP_W'(1);
  assign has_room    = count_x < lim;

  assign tail_sum = IDX_W'(head) + IDX_W'(count);
  assign tail     = (tail_sum >= IDX_W'(QUEUE_DEPTH)) ? PTR_W'(tail_sum - IDX_W'(QUEUE_DEPTH))
                                                      : PTR_W'(tail_sum);
  assign head_inc = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);

  assign arr_lt   = cur.job.arrival_time < server_time;
  assign arr_eq   = cur.job.arrival_time == server_time;
  assign out_free = !result_valid || !result_stall;

  assign head_entry = store[head];
  assign fin = sat_add(server_time, {{(TIME_W-LEN_W){1'b0}}, head_entry.run_length});

  // Whether the current request still owes a record after the one leaving now.
  always_comb begin
    if (draining) begin
      more = (count_after != '0);
    end else if (run_eq) begin
      more = cur.job.final_job;
    end else begin
      more = (cur.job.arrival_time >= run_server) || (count_after >= lim) ||
             cur.job.final_job;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (arr_lt) begin
          if (has_room) begin
            state_next = cur.job.final_job ? ST_RUN : ST_IDLE;
          end else if (out_free) begin
            state_next = (cur.job.final_job && count != '0) ? ST_RUN : ST_IDLE;
          end
        end else if (count != '0) begin
          state_next = ST_RUN;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RUN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (draining) begin
            state_next = more ? ST_RUN : ST_IDLE;
          end else if (run_eq) begin
            state_next = cur.job.final_job ? ST_RUN : ST_IDLE;
          end else begin
            state_next = ST_DECIDE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop      = 1'b0;
    emit         = 1'b0;
    emit_rec     = '0;
    push_cur     = 1'b0;
    pop_head     = 1'b0;
    load_server  = 1'b0;
    server_value = run_server;
    drain_start  = 1'b0;
    capture_run  = 1'b0;
    load_eq      = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_pop = cmd_valid;
      end
      ST_DECIDE: begin
        emit_rec.result_job_id = cur.job.job_id;
        if (arr_lt) begin
          if (has_room) begin
            push_cur    = 1'b1;
            drain_start = cur.job.final_job;
          end else if (out_free) begin
            emit                = 1'b1;
            emit_rec.outcome    = OUT_DROPPED;
            emit_rec.event_time = cur.job.arrival_time;
            emit_rec.run_end    = !(cur.job.final_job && count != '0);
            drain_start         = cur.job.final_job && count != '0;
          end
        end else if (count != '0) begin
          load_eq = 1'b1;
        end else if (out_free) begin
          emit                = 1'b1;
          emit_rec.outcome    = OUT_DONE;
          emit_rec.event_time = cur.idle_finish;
          emit_rec.run_end    = 1'b1;
          load_server         = 1'b1;
          server_value        = cur.idle_finish;
        end
      end
      ST_RUN: begin
        capture_run = 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_rec.result_job_id = head_entry.job_id;
          emit_rec.outcome       = run_outcome;
          emit_rec.event_time    = run_time;
          emit_rec.wait_delay    = run_delay;
          emit_rec.run_end       = !more;
          pop_head               = 1'b1;
          load_server            = 1'b1;
          push_cur               = !draining && run_eq;
          drain_start            = !draining && run_eq && cur.job.final_job;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      head        <= '0;
      count       <= '0;
      server_time <= '0;
      draining    <= 1'b0;
      run_eq      <= 1'b0;
    end else begin
      state <= state_next;
      if (pop_head) begin
        head <= head_inc;
      end
      count <= count + CNT_W'(push_cur) - CNT_W'(pop_head);
      if (load_server) begin
        server_time <= server_value;
      end
      if (state_next == ST_IDLE) begin
        draining <= 1'b0;
      end else if (drain_start) begin
        draining <= 1'b1;
      end
      if (load_eq) begin
        run_eq <= arr_eq;
      end else if (drain_start) begin
        run_eq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (push_cur) begin
      store[tail] <= '{job_id:       cur.job.job_id,
                       arrival_time: cur.job.arrival_time,
                       run_length:   cur.job.run_length,
                       deadline:     cur.job.deadline};
    end
  end

  // The head job is evaluated against the server time in one registered step.
  always_ff @(posedge clk) begin
    if (capture_run) begin
      if (server_time >= head_entry.deadline) begin
        run_outcome <= OUT_EXPIRED_WAIT;
        run_time    <= server_time;
        run_delay   <= sat_sub(server_time, head_entry.arrival_time);
        run_server  <= server_time;
      end else if (fin > head_entry.deadline) begin
        run_outcome <= OUT_EXPIRED_RUN;
        run_time    <= head_entry.deadline;
        run_delay   <= sat_sub(head_entry.deadline, head_entry.arrival_time);
        run_server  <= head_entry.deadline;
      end else begin
        run_outcome <= OUT_DONE;
        run_time    <= fin;
        run_delay   <= sat_sub(server_time, head_entry.arrival_time);
        run_server  <= fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_rec;
    end
  end

  assign status.state       = state;
  assign status.draining    = draining;
  assign status.queue_empty = (count == '0);

endmodule

@@ rtl/core/bounded_fifo_job_dispatcher_core.sv @@
// A request that meets an idle server with no waiting jobs passes through the front holding
// register, the request queue and the back end's request register before its record is
// registered. The back end takes one request at a time, runs each waiting job it starts
// through its run and emit steps, and is held by output stalls.
// Reset (rst, synchronous, active high) sets the queue limit to three, the server time
// to zero and empties both the request queue and the waiting-job store.
`timescale 1ns / 1ps

module bounded_fifo_job_dispatcher_core #(
  parameter int QUEUE_DEPTH = bfjd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bfjd_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic                         job_valid,
  output logic                         job_stall,
  input  bfjd_pkg::job_t               job,
  output logic                         result_valid,
  input  logic                         result_stall,
  output bfjd_pkg::result_t            result
);
  import bfjd_pkg::*;

  // The front stage registers each request and works out when it would finish on
  // an idle server. A two-entry request queue lets it keep accepting while the back
  // end is busy running waiting jobs or is held by a stalled output.
  logic [LIMIT_W-1:0] queue_limit;

  logic         front_push;
  logic         cmd_full;
  cmd_t         front_cmd;
  logic         cmd_valid;
  logic         cmd_pop;
  cmd_t         cmd_head;
  back_status_t back_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      queue_limit <= cfg_wdata;
    end
  end

  bfjd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .cmd_push  (front_push),
    .cmd_full  (cmd_full),
    .cmd       (front_cmd)
  );

  bfjd_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_cmd),
    .full      (cmd_full),
    .not_empty (cmd_valid),
    .pop       (cmd_pop),
    .head      (cmd_head)
  );

  // The back end owns the server time and the waiting-job FIFO. It takes one request
  // at a time, starts waiting jobs up to the arrival time, then queues, drops or
  // completes the new job, and drains the FIFO when the request is the last one.
  bfjd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_limit  (queue_limit),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd_head),
    .cmd_pop      (cmd_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .status       (back_status)
  );

`ifndef SYNTHESIS
  // The back end never takes a request from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("request taken from an empty queue");

  // A new record is loaded only from the decision or the emit step.
  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(back_status.state) == ST_DECIDE ||
                             $past(back_status.state) == ST_EMIT))
    else $error("record loaded outside a decision or emit step");

  // A drain is over by the time the back end returns to idle.
  a_drain_idle: assert property (@(posedge clk) disable iff (rst)
    back_status.draining |-> back_status.state != ST_IDLE)
    else $error("drain flag left set while idle");

  // Starting a waiting job during a drain needs one in the store.
  a_drain_run: assert property (@(posedge clk) disable iff (rst)
    (back_status.draining && back_status.state == ST_RUN) |-> !back_status.queue_empty)
    else $error("drain started a job from an empty store");
`endif

endmodule
